// ===== rtl/core/scfp_pkg.sv =====
`default_nettype none

package scfp_pkg;

  localparam logic [7:0] SYNC0    = 8'hAA;
  localparam logic [7:0] SYNC1    = 8'h55;
  localparam logic [7:0] ACK_FLAG = 8'h80;

  localparam logic [7:0] CMD_MOTION    = 8'h01;
  localparam logic [7:0] CMD_SERVO     = 8'h03;
  localparam logic [7:0] CMD_HEARTBEAT = 8'h05;
  localparam logic [7:0] CMD_ESTOP     = 8'h06;
  localparam logic [7:0] CMD_ACTION    = 8'h09;

  localparam logic [15:0] MIN_PULSE_RST = 16'd500;
  localparam logic [15:0] MAX_PULSE_RST = 16'd2500;

  localparam logic CFG_MIN_PULSE = 1'b0;
  localparam logic CFG_MAX_PULSE = 1'b1;

  typedef enum logic [2:0] {
    EFF_SERVO     = 3'd0,
    EFF_MOTION    = 3'd1,
    EFF_GAIT_STOP = 3'd2,
    EFF_ACTION    = 3'd3,
    EFF_ACK       = 3'd4
  } effect_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_CSUM     = 2'd1,
    STS_UNKNOWN  = 2'd2,
    STS_BADPARAM = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] len;
    logic       csum_ok;
    logic       len_mod3_zero;
  } job_t;

  typedef struct packed {
    effect_e     effect;
    logic [7:0]  ack_command;
    status_e     status;
    logic [3:0]  target_id;
    logic [31:0] amount;
    logic        kick;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/scfp_ram.sv =====
`default_nettype none

module scfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 24
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/scfp_front.sv =====
`default_nettype none

module scfp_front
  import scfp_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 24,
  parameter int unsigned AW          = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          burst_end_i,
  input  wire logic          store_lock_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output job_t               job_o,
  output logic               wr_en_o,
  output logic [AW-1:0]      wr_addr_o,
  output logic [7:0]         wr_data_o
);

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_GOT_AA  = 6'b000010,
    PH_LEN     = 6'b000100,
    PH_CMD     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_CSUM    = 6'b100000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] xor_q, xor_d;
  logic [1:0] mod3_q, mod3_d;
  logic       accept;
  logic [8:0] cnt_next;

  // payload bytes wait while the back end still reads the store; the checksum byte waits while the job queue is full
  assign in_stall_o = ((phase_q == PH_PAYLOAD) && store_lock_i) ||
                      ((phase_q == PH_CSUM) && q_full_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign cnt_next   = {1'b0, cnt_q} + 9'd1;

  assign wr_en_o   = accept && (phase_q == PH_PAYLOAD) &&
                     ({1'b0, cnt_q} < 9'(STORE_DEPTH));
  assign wr_addr_o = cnt_q[AW-1:0];
  assign wr_data_o = rx_byte_i;

  assign push_o = accept && (phase_q == PH_CSUM);
  assign job_o  = '{cmd: cmd_q, len: len_q, csum_ok: (xor_q == rx_byte_i),
                    len_mod3_zero: (mod3_q == 2'd0)};

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cmd_d   = cmd_q;
    cnt_d   = cnt_q;
    xor_d   = xor_q;
    mod3_d  = mod3_q;
    if (accept) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == SYNC0) begin
            phase_d = PH_GOT_AA;
          end
        end
        PH_GOT_AA: begin
          if (rx_byte_i == SYNC1) begin
            phase_d = PH_LEN;
          end else if (rx_byte_i != SYNC0) begin
            phase_d = PH_HUNT;
          end
        end
        PH_LEN: begin
          len_d   = rx_byte_i;
          xor_d   = rx_byte_i;
          cnt_d   = '0;
          mod3_d  = '0;
          phase_d = PH_CMD;
        end
        PH_CMD: begin
          cmd_d   = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = (len_q == 8'd0) ? PH_CSUM : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          xor_d  = xor_q ^ rx_byte_i;
          cnt_d  = cnt_next[7:0];
          mod3_d = (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
          if (cnt_next >= {1'b0, len_q}) begin
            phase_d = PH_CSUM;
          end
        end
        PH_CSUM: begin
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
      if (burst_end_i) begin
        phase_d = PH_HUNT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      cmd_q   <= '0;
      cnt_q   <= '0;
      xor_q   <= '0;
      mod3_q  <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cmd_q   <= cmd_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
      mod3_q  <= mod3_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/scfp_jobq.sv =====
`default_nettype none

module scfp_jobq
  import scfp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  input  wire logic pop_i,
  output job_t      job_o,
  output logic      full_o,
  output logic      empty_o
);

  job_t       slot_q [2];
  job_t       slot_d [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign job_o   = slot_q[rd_ptr_q];

  always_comb begin
    slot_d   = slot_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      slot_d[wr_ptr_q] = job_i;
      wr_ptr_d         = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job queue written while full");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/scfp_back.sv =====
`default_nettype none

module scfp_back
  import scfp_pkg::*;
#(
  parameter int unsigned SERVO_ENTRIES = 8,
  parameter int unsigned STORE_DEPTH   = 24,
  parameter int unsigned AW            = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [15:0]   min_pulse_i,
  input  wire logic [15:0]   max_pulse_i,
  input  wire logic          q_empty_i,
  input  wire job_t          job_i,
  output logic               pop_o,
  output logic               idle_o,
  output logic               rd_en_o,
  output logic [AW-1:0]      rd_addr_o,
  input  wire logic [7:0]    rd_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output result_t            res_o
);

  localparam int unsigned CW     = $clog2(STORE_DEPTH + 1);
  localparam int unsigned STEP_W = $clog2(((SERVO_ENTRIES > 2) ? SERVO_ENTRIES : 2) + 1);

  typedef enum logic [4:0] {
    BK_IDLE    = 5'b00001,
    BK_DECIDE  = 5'b00010,
    BK_READ    = 5'b00100,
    BK_CAPTURE = 5'b01000,
    BK_EMIT    = 5'b10000
  } bk_state_e;

  function automatic result_t mk_ack(input logic [7:0] cmd, input status_e sts);
    result_t r;
    r.effect      = EFF_ACK;
    r.ack_command = cmd | ACK_FLAG;
    r.status      = sts;
    r.target_id   = '0;
    r.amount      = '0;
    r.kick        = (sts == STS_OK);
    r.last        = 1'b1;
    return r;
  endfunction

  function automatic result_t mk_eff(input effect_e eff, input logic [3:0] id,
                                     input logic [31:0] amt);
    result_t r;
    r.effect      = eff;
    r.ack_command = '0;
    r.status      = STS_OK;
    r.target_id   = id;
    r.amount      = amt;
    r.kick        = 1'b0;
    r.last        = 1'b0;
    return r;
  endfunction

  bk_state_e        state_q, state_d;
  job_t             job_q, job_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic             fetched_q, fetched_d;
  logic [2:0]       need_q, need_d;
  logic [2:0]       sub_q, sub_d;
  logic [CW-1:0]    addr_q, addr_d;
  logic [7:0]       buf_q [5];
  logic [7:0]       buf_d [5];
  result_t          res_q, res_d;
  result_t          out_q, out_d;
  logic             out_valid_q, out_valid_d;

  result_t          dec_res;
  logic             dec_fetch;
  logic [2:0]       dec_need;
  logic             out_free;
  logic [15:0]      pulse;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = (state_q == BK_IDLE) && !q_empty_i;
  assign idle_o      = (state_q == BK_IDLE);
  assign rd_en_o     = (state_q == BK_READ);
  assign rd_addr_o   = addr_q[AW-1:0];
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign pulse       = {buf_q[2], buf_q[1]};

  // what the current job does next: fetch bytes or produce one result
  always_comb begin
    dec_fetch = 1'b0;
    dec_need  = 3'd0;
    dec_res   = mk_ack(job_q.cmd, STS_OK);
    if (!job_q.csum_ok) begin
      dec_res = mk_ack(job_q.cmd, STS_CSUM);
    end else begin
      case (job_q.cmd)
        CMD_MOTION: begin
          if (job_q.len != 8'd5) begin
            dec_res = mk_ack(job_q.cmd, STS_BADPARAM);
          end else if (step_q != '0) begin
            dec_res = mk_ack(job_q.cmd, STS_OK);
          end else if (!fetched_q) begin
            dec_fetch = 1'b1;
            dec_need  = 3'd5;
          end else if (buf_q[0] < 8'd1 || buf_q[0] > 8'd4) begin
            dec_res = mk_ack(job_q.cmd, STS_BADPARAM);
          end else begin
            dec_res = mk_eff(EFF_MOTION, buf_q[0][3:0],
                             {buf_q[4], buf_q[3], buf_q[2], buf_q[1]});
          end
        end
        CMD_SERVO: begin
          if (job_q.len == 8'd0 || !job_q.len_mod3_zero) begin
            dec_res = mk_ack(job_q.cmd, STS_BADPARAM);
          end else if (!fetched_q) begin
            if (step_q == STEP_W'(SERVO_ENTRIES) || 9'(addr_q) == {1'b0, job_q.len}) begin
              dec_res = mk_ack(job_q.cmd, STS_OK);
            end else begin
              dec_fetch = 1'b1;
              dec_need  = 3'd3;
            end
          end else if (buf_q[0] >= 8'(SERVO_ENTRIES) || pulse < min_pulse_i ||
                       pulse > max_pulse_i) begin
            dec_res = mk_ack(job_q.cmd, STS_BADPARAM);
          end else begin
            dec_res = mk_eff(EFF_SERVO, buf_q[0][3:0], 32'(pulse));
          end
        end
        CMD_HEARTBEAT: begin
          dec_res = mk_ack(job_q.cmd, STS_OK);
        end
        CMD_ESTOP: begin
          if (step_q == STEP_W'(0)) begin
            dec_res = mk_eff(EFF_GAIT_STOP, 4'd0, 32'd0);
          end else if (step_q == STEP_W'(1)) begin
            dec_res = mk_eff(EFF_MOTION, 4'd1, 32'd0);
          end else begin
            dec_res = mk_ack(job_q.cmd, STS_OK);
          end
        end
        CMD_ACTION: begin
          if (job_q.len < 8'd2) begin
            dec_res = mk_ack(job_q.cmd, STS_BADPARAM);
          end else if (step_q != '0) begin
            dec_res = mk_ack(job_q.cmd, STS_OK);
          end else if (!fetched_q) begin
            dec_fetch = 1'b1;
            dec_need  = (job_q.len >= 8'd4) ? 3'd4 : 3'd2;
          end else if (buf_q[0] < 8'd1 || buf_q[0] > 8'd8) begin
            dec_res = mk_ack(job_q.cmd, STS_BADPARAM);
          end else begin
            dec_res = mk_eff(EFF_ACTION, buf_q[0][3:0], 32'({buf_q[3], buf_q[2]}));
          end
        end
        default: begin
          dec_res = mk_ack(job_q.cmd, STS_UNKNOWN);
        end
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    step_d      = step_q;
    fetched_d   = fetched_q;
    need_d      = need_q;
    sub_d       = sub_q;
    addr_d      = addr_q;
    buf_d       = buf_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          job_d     = job_i;
          step_d    = '0;
          fetched_d = 1'b0;
          addr_d    = '0;
          for (int i = 0; i < 5; i++) begin
            buf_d[i] = '0;
          end
          state_d = BK_DECIDE;
        end
      end
      BK_DECIDE: begin
        if (dec_fetch) begin
          need_d  = dec_need;
          sub_d   = '0;
          state_d = BK_READ;
        end else begin
          res_d   = dec_res;
          state_d = BK_EMIT;
        end
      end
      BK_READ: begin
        state_d = BK_CAPTURE;
      end
      BK_CAPTURE: begin
        buf_d[sub_q] = rd_data_i;
        addr_d       = addr_q + CW'(1);
        if (sub_q + 3'd1 == need_q) begin
          fetched_d = 1'b1;
          state_d   = BK_DECIDE;
        end else begin
          sub_d   = sub_q + 3'd1;
          state_d = BK_READ;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          if (res_q.last) begin
            state_d = BK_IDLE;
          end else begin
            step_d    = step_q + STEP_W'(1);
            fetched_d = 1'b0;
            state_d   = BK_DECIDE;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    buf_q <= buf_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= '0;
      fetched_q   <= 1'b0;
      need_q      <= '0;
      sub_q       <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      fetched_q   <= fetched_d;
      need_q      <= need_d;
      sub_q       <= sub_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/servo_command_frame_parser_top.sv =====
`default_nettype none

// bytes are taken one per cycle when not stalled; payload bytes wait while the
// back end is busy or a job is queued, and the checksum byte waits while the
// job queue is full; results wait on the store reads that their job needs (5
// for motion play, 2 or 4 for action play, 3 per servo entry)
// reset returns the parser to header hunt, empties the job queue and sets
// pulse limits to 500 and 2500; the payload store is not cleared

module servo_command_frame_parser_top
  import scfp_pkg::*;
#(
  parameter int unsigned SERVO_ENTRIES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        burst_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       effect_o,
  output logic [7:0]       ack_command_o,
  output logic [1:0]       status_o,
  output logic [3:0]       target_id_o,
  output logic [31:0]      amount_o,
  output logic             kick_watchdog_o,
  output logic             last_o
);

  localparam int unsigned STORE_DEPTH = ((SERVO_ENTRIES * 3) > 5) ? (SERVO_ENTRIES * 3) : 5;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);

  logic [15:0]   min_pulse_q;
  logic [15:0]   max_pulse_q;
  logic          push;
  job_t          push_job;
  job_t          head_job;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  logic          back_idle;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  result_t       res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pulse_q <= MIN_PULSE_RST;
      max_pulse_q <= MAX_PULSE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_PULSE: min_pulse_q <= cfg_data_i;
        CFG_MAX_PULSE: max_pulse_q <= cfg_data_i;
        default:       min_pulse_q <= min_pulse_q;
      endcase
    end
  end

  scfp_front #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .burst_end_i  (burst_end_i),
    .store_lock_i (!back_idle || !q_empty),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (push_job),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  scfp_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  scfp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  scfp_back #(
    .SERVO_ENTRIES (SERVO_ENTRIES),
    .STORE_DEPTH   (STORE_DEPTH),
    .AW            (AW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_pulse_i (min_pulse_q),
    .max_pulse_i (max_pulse_q),
    .q_empty_i   (q_empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .idle_o      (back_idle),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign effect_o        = res.effect;
  assign ack_command_o   = res.ack_command;
  assign status_o        = res.status;
  assign target_id_o     = res.target_id;
  assign amount_o        = res.amount;
  assign kick_watchdog_o = res.kick;
  assign last_o          = res.last;

`ifndef SYNTHESIS
  a_store_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (back_idle && q_empty))
    else $error("payload store written while a frame is being executed");

  a_last_is_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (effect_o == EFF_ACK)))
    else $error("last flag does not match acknowledge");

  a_kick_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kick_watchdog_o) |-> (status_o == STS_OK && last_o))
    else $error("watchdog kick on a result that is not an ok acknowledge");
`endif

endmodule

`default_nettype wire
